// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with explicit clock and active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Short form for modules that use clk_i and rst_ni.
`define ASSERT_CLK(label, prop, msg) `ASSERT_IMPL(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/spmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multi-level FIFO package
// Field widths, parameter defaults, request codes and controller states.
// ----------------------------------------------------------------------------
package spmf_pkg;

  // Parameter defaults.
  localparam int LevelsDef    = 8;
  localparam int DepthDef     = 16;
  localparam int DataWidthDef = 32;

  // Fixed widths of the request and response fields.
  localparam int ValueW = 32;
  localparam int LevelW = 3;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR,
    ST_DATA
  } state_e;

endpackage

// ===== rtl/spmf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multi-level FIFO channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spmf_req_if;
  logic                        valid;
  logic                        ready;
  spmf_pkg::req_e              req_type;
  logic [spmf_pkg::ValueW-1:0] item_value;
  logic [spmf_pkg::LevelW-1:0] priority_req;

  modport source (output valid, output req_type, output item_value,
                  output priority_req, input ready);
  modport sink   (input valid, input req_type, input item_value,
                  input priority_req, output ready);
endinterface

interface spmf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [spmf_pkg::ValueW-1:0] result_value;
  logic [spmf_pkg::LevelW-1:0] served_level;

  modport source (output valid, output success, output result_value,
                  output served_level, input ready);
  modport sink   (input valid, input success, input result_value,
                  input served_level, output ready);
endinterface

// ===== rtl/spmf_level_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level pointer table
// Per-level head, tail and fill count in a synchronous memory, with
// per-entry valid bits and per-level non-empty and full flags.
// ----------------------------------------------------------------------------
module spmf_level_table #(
  parameter int LEVELS = spmf_pkg::LevelsDef,
  parameter int DEPTH  = spmf_pkg::DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(LEVELS)-1:0]  rd_lvl_i,
  output logic [$clog2(DEPTH)-1:0]   rd_head_o,
  output logic [$clog2(DEPTH)-1:0]   rd_tail_o,
  output logic [$clog2(DEPTH+1)-1:0] rd_count_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(LEVELS)-1:0]  wr_lvl_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_head_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_tail_i,
  input  logic [$clog2(DEPTH+1)-1:0] wr_count_i,
  output logic [LEVELS-1:0]          nonempty_o,
  output logic [LEVELS-1:0]          full_o
);
  import spmf_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int RecW = 2 * IdxW + CntW;

  logic [RecW-1:0]   mem_q [LEVELS];
  logic [RecW-1:0]   rd_rec_q;
  logic              rd_vld_q;
  logic [LEVELS-1:0] entry_vld_q;
  logic [LEVELS-1:0] nonempty_q;
  logic [LEVELS-1:0] full_q;

  // Pointer memory: one write and one read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_lvl_i] <= {wr_head_i, wr_tail_i, wr_count_i};
    end
    if (rd_en_i) begin
      rd_rec_q <= mem_q[rd_lvl_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      entry_vld_q <= '0;
      nonempty_q  <= '0;
      full_q      <= '0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= entry_vld_q[rd_lvl_i];
      end
      if (wr_en_i) begin
        entry_vld_q[wr_lvl_i] <= 1'b1;
        nonempty_q[wr_lvl_i]  <= (wr_count_i != '0);
        full_q[wr_lvl_i]      <= (wr_count_i == CntW'(DEPTH));
      end
    end
  end

  // An entry never written reads as its reset value of zero.
  always_comb begin
    if (rd_vld_q) begin
      {rd_head_o, rd_tail_o, rd_count_o} = rd_rec_q;
    end else begin
      rd_head_o  = '0;
      rd_tail_o  = '0;
      rd_count_o = '0;
    end
  end

  assign nonempty_o = nonempty_q;
  assign full_o     = full_q;

endmodule

// ===== rtl/strict_priority_multi_fifo_top.sv =====
// A request transferred in ST_IDLE passes the pointer memory read, the data
// memory access and the output register load in turn. The load waits while
// an unaccepted result is still held; new requests wait for the load.
// The response register holds a finished result while the next request runs.
// Reset (asynchronous, active low) empties every level at once through the
// per-level valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Strict priority multi-level FIFO
// One bounded ring per priority level in a shared data memory. An add request
// appends to its level; a remove request pops the lowest-numbered non-empty
// level and reports the level that served it.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_top #(
  parameter int LEVELS     = spmf_pkg::LevelsDef,
  parameter int DEPTH      = spmf_pkg::DepthDef,
  parameter int DATA_WIDTH = spmf_pkg::DataWidthDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  spmf_req_if.sink     req_i,
  spmf_rsp_if.source   rsp_o
);
  import spmf_pkg::*;

  localparam int LvlW    = $clog2(LEVELS);
  localparam int IdxW    = $clog2(DEPTH);
  localparam int CntW    = $clog2(DEPTH + 1);
  localparam int Entries = LEVELS * DEPTH;
  localparam int AddrW   = $clog2(Entries);

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  req_e                  op_q;
  logic [LvlW-1:0]       lvl_q;
  logic                  go_q;
  logic [DATA_WIDTH-1:0] word_q;

  logic                  req_xfer;
  logic                  req_ready;
  logic [LEVELS-1:0]     nonempty;
  logic [LEVELS-1:0]     full;
  logic [LvlW-1:0]       top_lvl;
  logic                  any_ne;
  logic [LvlW-1:0]       add_lvl;
  logic                  add_in_range;
  logic                  add_go;

  assign req_xfer    = req_i.valid && req_ready;
  assign req_i.ready = req_ready;

  // Strict priority: the lowest-numbered non-empty level wins.
  always_comb begin
    top_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        top_lvl = LvlW'(i);
      end
    end
  end

  assign any_ne       = |nonempty;
  assign add_lvl      = LvlW'(req_i.priority_req);
  assign add_in_range = int'(req_i.priority_req) < LEVELS;
  // A level beyond the configured count, or a full level, rejects the add.
  assign add_go       = add_in_range && !full[add_lvl];

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q   <= req_i.req_type;
      word_q <= DATA_WIDTH'(req_i.item_value);
      if (req_i.req_type == REQ_REMOVE) begin
        lvl_q <= top_lvl;
        go_q  <= any_ne;
      end else begin
        lvl_q <= add_lvl;
        go_q  <= add_go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pointer table and ring update
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]  ptr_head, ptr_tail;
  logic [CntW-1:0]  ptr_count;
  logic [IdxW-1:0]  new_head, new_tail;
  logic [CntW-1:0]  new_count;
  logic             data_we, data_re;
  logic [AddrW-1:0] data_addr;

  spmf_level_table #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_level_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (req_xfer),
    .rd_lvl_i   ((req_i.req_type == REQ_REMOVE) ? top_lvl : add_lvl),
    .rd_head_o  (ptr_head),
    .rd_tail_o  (ptr_tail),
    .rd_count_o (ptr_count),
    .wr_en_i    (data_we || data_re),
    .wr_lvl_i   (lvl_q),
    .wr_head_i  (new_head),
    .wr_tail_i  (new_tail),
    .wr_count_i (new_count),
    .nonempty_o (nonempty),
    .full_o     (full)
  );

  // The pointer read issued on the transfer is back in ST_PTR, where the
  // level's ring is advanced and written back. The next request can only be
  // transferred in ST_IDLE, after that write, so no forwarding is needed.
  always_comb begin
    new_head  = ptr_head;
    new_tail  = ptr_tail;
    new_count = ptr_count;
    if (op_q == REQ_ADD) begin
      new_tail  = (ptr_tail == IdxW'(DEPTH - 1)) ? '0 : ptr_tail + 1'b1;
      new_count = ptr_count + 1'b1;
    end else begin
      new_head  = (ptr_head == IdxW'(DEPTH - 1)) ? '0 : ptr_head + 1'b1;
      new_count = ptr_count - 1'b1;
    end
  end

  assign data_addr = AddrW'(lvl_q) * AddrW'(DEPTH)
                   + AddrW'((op_q == REQ_ADD) ? ptr_tail : ptr_head);

  // ---------------------------------------------------------------------------
  // Data memory: one ring of DEPTH words per level, read data registered.
  // Entries are undefined until written and are only read once written.
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] data_mem_q [Entries];
  logic [DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem_q[data_addr] <= word_q;
    end
    if (data_re) begin
      rd_data_q <= data_mem_q[data_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_vld_q;
  logic out_load;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          state_d = ST_PTR;
        end
      end
      ST_PTR: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    data_we   = 1'b0;
    data_re   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_PTR: begin
        data_we = go_q && (op_q == REQ_ADD);
        data_re = go_q && (op_q == REQ_REMOVE);
      end
      ST_DATA: begin
        // The response register is free, or is emptied by this cycle's transfer.
        out_load = !out_vld_q || rsp_o.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------------
  logic              out_success_q;
  logic [ValueW-1:0] out_value_q;
  logic [LevelW-1:0] out_served_q;
  logic              served;

  // Only a successful remove carries a data word and a level; all other
  // responses report zero in both fields.
  assign served = go_q && (op_q == REQ_REMOVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_success_q <= go_q;
      out_value_q   <= served ? ValueW'(rd_data_q) : '0;
      out_served_q  <= served ? LevelW'(lvl_q) : '0;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.success      = out_success_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.served_level = out_served_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(xfer_starts_op_a, req_xfer |=> state_q == ST_PTR, "request transfer did not start an operation")
  `ASSERT_CLK(ptr_then_data_a, state_q == ST_PTR |=> state_q == ST_DATA, "pointer stage not followed by data stage")
  `ASSERT_CLK(full_is_nonempty_a, (full & ~nonempty) == '0, "level flagged full but empty")
  `ASSERT_CLK(mem_access_gated_a, (data_we || data_re) |-> (go_q && state_q == ST_PTR), "data memory accessed without a valid operation")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multi-level FIFO testbench
// Drives add and remove requests into the block, keeps its own per-level
// queues as a predictor and checks every response field against it, with
// random gaps on the request side and random back-pressure on the response.
// ----------------------------------------------------------------------------
module tb;
  import spmf_pkg::*;

  // The block is built with its package defaults, so the predictor uses them too.
  localparam int Levels    = LevelsDef;
  localparam int Depth     = DepthDef;
  localparam int DataWidth = DataWidthDef;

  localparam int RandomItems = 1750;
  // The limit covers the worst case per item: the longest sender gap, the
  // longest receiver stall and the block's own processing of the item.
  localparam int CycleLimit  = 900000;
  localparam int HoldAt      = 600;  // transfers before the long receiver hold
  localparam int HoldCycles  = 400;
  localparam int DrainEvery  = 400;  // random items between full drains
  localparam int MaxPrinted  = 100;

  typedef struct {
    req_e              kind;
    logic [ValueW-1:0] word;
    logic [LevelW-1:0] level;
    int unsigned       gap;    // idle cycles before the item is offered
    bit                drain;  // wait for every outstanding response first
  } queue_req_t;

  typedef struct {
    logic              success;
    logic [ValueW-1:0] value;
    logic [LevelW-1:0] level;
  } queue_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spmf_req_if req_if ();
  spmf_rsp_if rsp_if ();

  strict_priority_multi_fifo_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus waiting to be offered, responses still owed by the block, and
  // the predicted contents of every level.
  queue_req_t         request_queue[$];
  queue_rsp_t         due_responses[$];
  logic [DataWidth-1:0] level_fifo[Levels][$];

  int unsigned sent_cnt  = 0;
  int unsigned got_cnt   = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // Applies one request to the predicted levels and returns the response it
  // should produce: adds append to their own level unless it is full or out
  // of range, removes pop the lowest-numbered level that holds anything.
  function automatic queue_rsp_t serve_request(queue_req_t rq);
    queue_rsp_t rsp;
    bit         found;
    rsp   = '{success: 1'b0, value: '0, level: '0};
    found = 1'b0;
    if (rq.kind == REQ_ADD) begin
      if (rq.level < Levels && level_fifo[rq.level].size() < Depth) begin
        level_fifo[rq.level].push_back(DataWidth'(rq.word));
        rsp.success = 1'b1;
      end
    end else begin
      for (int lvl = 0; lvl < Levels; lvl++) begin
        if (!found && level_fifo[lvl].size() != 0) begin
          found       = 1'b1;
          rsp.success = 1'b1;
          rsp.value   = ValueW'(level_fifo[lvl].pop_front());
          rsp.level   = LevelW'(lvl);
        end
      end
    end
    return rsp;
  endfunction

  // Counts every mismatch; the printout is capped so that a badly broken
  // block cannot flood the log.
  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Data words lean towards the all-zero and all-one patterns now and then.
  function automatic logic [ValueW-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ValueW'($urandom());
  endfunction

  task automatic push_item(input req_e kind, input logic [ValueW-1:0] word,
                           input logic [LevelW-1:0] level, input int unsigned gap,
                           input bit drain);
    queue_req_t rq;
    rq.kind  = kind;
    rq.word  = word;
    rq.level = level;
    rq.gap   = gap;
    rq.drain = drain;
    request_queue.push_back(rq);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned made;
    int unsigned phase_len;
    int unsigned add_pct;
    int unsigned mode;
    int unsigned focus;
    int unsigned next_drain;
    bit          burst;
    req_e        kind;
    logic [LevelW-1:0] lvl;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_ADD;
    req_if.item_value    = '0;
    req_if.priority_req  = '0;
    rsp_if.ready         = 1'b0;

    // Directed part. A remove on an empty queue comes first, then one word at
    // each end of the level range and one at level 4, to show that level 0 is served before
    // level 7 whatever the arrival order.
    push_item(REQ_REMOVE, '1, '1, 0, 1'b0);
    push_item(REQ_ADD, '1, LevelW'(Levels - 1), 0, 1'b0);
    push_item(REQ_ADD, '0, '0, 0, 1'b0);
    push_item(REQ_ADD, 32'hA5A5_5A5A, 3'd4, 0, 1'b0);
    push_item(REQ_REMOVE, '0, '0, 0, 1'b0);
    push_item(REQ_REMOVE, '0, '0, 0, 1'b0);
    push_item(REQ_REMOVE, 32'h1234_5678, 3'd2, 0, 1'b0);
    push_item(REQ_REMOVE, '0, '0, 0, 1'b0);
    // Fill one level to its depth; the add after that must be turned away.
    for (int i = 0; i < Depth; i++) begin
      push_item(REQ_ADD, ValueW'(32'h5000_0000 + i), 3'd5, 0, 1'b0);
    end
    push_item(REQ_ADD, 32'hDEAD_BEEF, 3'd5, 0, 1'b0);
    push_item(REQ_REMOVE, '0, '0, 0, 1'b0);
    // Out-of-range levels cannot occur while Levels fills the 3-bit field.

    // Random part, in phases that lean towards filling or draining the
    // levels so that full levels and an empty queue both come up often.
    made       = 0;
    next_drain = 0;
    while (made < RandomItems) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0:       add_pct = 85;
        1:       add_pct = 50;
        default: add_pct = 20;
      endcase
      mode  = $urandom_range(0, 2);
      focus = $urandom_range(0, Levels - 1);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && made < RandomItems; i++) begin
        kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_REMOVE;
        case (mode)
          0:       lvl = LevelW'($urandom_range(0, Levels - 1));
          1:       lvl = ($urandom_range(0, 9) < 8) ? LevelW'(focus)
                                                    : LevelW'($urandom_range(0, Levels - 1));
          default: lvl = ($urandom_range(0, 1) == 0) ? LevelW'($urandom_range(0, 1))
                                                     : LevelW'(Levels - 1 - $urandom_range(0, 1));
        endcase
        push_item(kind, pick_word(), lvl, burst ? 0 : pick_gap(), made == next_drain);
        if (made == next_drain) begin
          next_drain += DrainEvery;
        end
        made++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The transfer count covers the edge at which the last request has left
    // the queue but its prediction has not been recorded yet.
    while (request_queue.size() != 0 || due_responses.size() != 0 ||
           sent_cnt != got_cnt) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && due_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver. A new item goes out once its gap has passed and, where
  // it asks for a full drain, once every earlier transfer has been answered.
  // --------------------------------------------------------------------------
  int unsigned idle_run = 0;

  always @(posedge clk_i) begin : drive_requests
    logic fire;
    fire = req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (fire) begin
        request_queue.delete(0);
        sent_cnt++;
        idle_run = 0;
      end
      // While an offer is pending it is held unchanged.
      if (!req_if.valid || fire) begin
        if (request_queue.size() != 0 && idle_run >= request_queue[0].gap &&
            (!request_queue[0].drain || sent_cnt == got_cnt)) begin
          req_if.valid        <= 1'b1;
          req_if.req_type     <= request_queue[0].kind;
          req_if.item_value   <= request_queue[0].word;
          req_if.priority_req <= request_queue[0].level;
        end else begin
          req_if.valid <= 1'b0;
          idle_run++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response back-pressure. The stall rate is redrawn for each window, with
  // some windows free of stalls, and once the receiver holds off for a long
  // stretch while requests keep coming, so that the block backs up.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_pct  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      if (!hold_done && sent_cnt >= HoldAt) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Responses are checked before the request of the same edge is
  // predicted; as every response is registered after its request's pointer and
  // data stages, no response can overtake the prediction for its own request.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    queue_rsp_t want;
    queue_req_t seen;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_cnt++;
        if (due_responses.size() == 0) begin
          report_mismatch("response with no request outstanding",
                          rsp_if.result_value, '0);
        end else begin
          want = due_responses.pop_front();
          if (rsp_if.success !== want.success) begin
            report_mismatch("success", ValueW'(rsp_if.success), ValueW'(want.success));
          end
          if (rsp_if.result_value !== want.value) begin
            report_mismatch("result_value", rsp_if.result_value, want.value);
          end
          if (rsp_if.served_level !== want.level) begin
            report_mismatch("served_level", ValueW'(rsp_if.served_level),
                            ValueW'(want.level));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.kind  = req_if.req_type;
        seen.word  = req_if.item_value;
        seen.level = req_if.priority_req;
        seen.gap   = 0;
        seen.drain = 1'b0;
        due_responses.push_back(serve_request(seen));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("[%0t] run stopped after %0d cycles", $time, cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
